### hw/rtl/fpt_pkg.sv
// Shared definitions for the fret position tracker: widths, operation and
// register codes, the default calibration table and small helper functions.
// Depends on nothing; every other file of the block imports it.
package fpt_pkg;

    localparam int FRET_COUNT = 17;
    localparam int FRET_IDX_W = $clog2(FRET_COUNT);

    localparam int SAMPLE_W   = 10;
    localparam int TIME_W     = 32;
    localparam int CONF_MS_W  = 16;
    localparam int NOTE_W     = 7;
    localparam int MARGIN_W   = 8;
    localparam int CAL_IDX_W  = 5;
    localparam int FRET_NUM_W = 5;
    localparam int OP_W       = 2;
    localparam int PHASE_W    = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef logic [FRET_IDX_W-1:0] t_fret_idx;
    typedef logic [SAMPLE_W-1:0]   t_sample;
    typedef logic [NOTE_W-1:0]     t_note;

    localparam t_fret_idx LAST_FRET = FRET_IDX_W'(FRET_COUNT - 1);
    localparam logic [CAL_IDX_W:0] CAL_LIMIT = (CAL_IDX_W + 1)'(FRET_COUNT);

    // Item operations.
    localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
    localparam logic [OP_W-1:0] OP_STRUM  = 2'd1;
    localparam logic [OP_W-1:0] OP_LOAD   = 2'd2;

    // Finger qualifier phases.
    localparam logic [PHASE_W-1:0] PH_NONE      = 2'd0;
    localparam logic [PHASE_W-1:0] PH_PRESSING  = 2'd1;
    localparam logic [PHASE_W-1:0] PH_DOWN      = 2'd2;
    localparam logic [PHASE_W-1:0] PH_RELEASING = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_TH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_TH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_MS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_MS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_JUMP_MS    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_NOTE  = 3'd6;

    // Configuration reset values.
    localparam t_sample                RST_PRESS_TH   = 10'd55;
    localparam t_sample                RST_RELEASE_TH = 10'd35;
    localparam logic [MARGIN_W-1:0]    RST_MARGIN     = 8'd6;
    localparam logic [CONF_MS_W-1:0]   RST_PRESS_MS   = 16'd4;
    localparam logic [CONF_MS_W-1:0]   RST_RELEASE_MS = 16'd120;
    localparam logic [CONF_MS_W-1:0]   RST_JUMP_MS    = 16'd8;
    localparam t_note                  RST_OPEN_NOTE  = 7'd64;

    localparam t_note NOTE_MAX = 7'd127;

    // Request from the tracker to the boundary scanner.
    typedef struct packed {
        logic                start;
        t_sample             value;
        t_fret_idx           cur;
        logic [MARGIN_W-1:0] margin;
    } t_scan_req;

    // Scanner status; raw holds while done is high, hyst follows the request's value, cur and margin.
    typedef struct packed {
        logic      done;
        t_fret_idx raw;
        t_fret_idx hyst;
    } t_scan_rsp;

    // Factory calibration: reading at the center of each fret.
    function automatic t_sample default_center(input logic [CAL_IDX_W-1:0] idx);
        t_sample val;
        case (idx)
            5'd0:    val = 10'd998;
            5'd1:    val = 10'd916;
            5'd2:    val = 10'd828;
            5'd3:    val = 10'd756;
            5'd4:    val = 10'd681;
            5'd5:    val = 10'd613;
            5'd6:    val = 10'd551;
            5'd7:    val = 10'd503;
            5'd8:    val = 10'd438;
            5'd9:    val = 10'd391;
            5'd10:   val = 10'd344;
            5'd11:   val = 10'd291;
            5'd12:   val = 10'd250;
            5'd13:   val = 10'd208;
            5'd14:   val = 10'd169;
            5'd15:   val = 10'd133;
            default: val = 10'd99;
        endcase
        return val;
    endfunction

    function automatic t_sample median3(input t_sample a, input t_sample b,
                                        input t_sample c);
        t_sample lo;
        t_sample hi;
        t_sample m;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        m  = (hi < c) ? hi : c;
        return (lo > m) ? lo : m;
    endfunction

    // Note of the open string plus the fret number, saturated at the MIDI top.
    function automatic t_note fretted_note(input t_note open_note, input t_fret_idx fret);
        logic [NOTE_W+1:0] sum;
        sum = (NOTE_W + 2)'(open_note) + (NOTE_W + 2)'(fret) + (NOTE_W + 2)'(1);
        return (sum > (NOTE_W + 2)'(NOTE_MAX)) ? NOTE_MAX : sum[NOTE_W-1:0];
    endfunction

endpackage

### hw/rtl/fret_position_tracker.sv
// Fret position tracker top level: configuration registers, press/release
// qualifier, fret commit and note logic, result register.
// Depends on fpt_pkg, fpt_cal_mem and fpt_fret_scan.

// The block tracks the finger on one string of a resistive neck sensor. Each
// input transfer carries one item: a sensor sample (three readings and a
// millisecond time, reduced to their median), a strum that arms the string,
// or a load of one calibration entry. Every item yields exactly one result
// transfer with the finger status, the committed fret and any note-on or
// note-off it caused. Items are processed one at a time. A sample waits for
// the scan that reads the calibration memory one entry per cycle to find the
// fret boundaries; a strum, a load or an unknown operation is applied without
// a scan. A finished result sits in an output register, so the next item is
// taken while the previous result waits; the block stalls only when a second
// result is ready before the first has been taken. The calibration memory
// needs no clearing pass: entries that were never loaded read back as their
// factory values. Configuration writes are always taken and are meant to
// arrive only while no item is in flight.
module fret_position_tracker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Item input channel.
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [fpt_pkg::OP_W-1:0]      i_opcode,
    input  fpt_pkg::t_sample              i_sample_a,
    input  fpt_pkg::t_sample              i_sample_b,
    input  fpt_pkg::t_sample              i_sample_c,
    input  logic [fpt_pkg::TIME_W-1:0]    i_now_ms,
    input  logic [fpt_pkg::CAL_IDX_W-1:0] i_cal_index,
    input  fpt_pkg::t_sample              i_cal_value,
    // Result channel.
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_finger_present,
    output logic [fpt_pkg::FRET_NUM_W-1:0] o_fret_number,
    output logic                          o_note_on_valid,
    output fpt_pkg::t_note                o_note_on_number,
    output logic                          o_note_off_valid,
    output fpt_pkg::t_note                o_note_off_number,
    // Configuration write channel.
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [fpt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [fpt_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import fpt_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    // Configuration.
    t_sample                r_press_th;
    t_sample                r_release_th;
    logic [MARGIN_W-1:0]    r_margin;
    logic [CONF_MS_W-1:0]   r_press_ms;
    logic [CONF_MS_W-1:0]   r_release_ms;
    logic [CONF_MS_W-1:0]   r_jump_ms;
    t_note                  r_open_note;

    // Item in flight.
    logic                   r_state;
    logic [OP_W-1:0]        r_op;
    t_sample                r_med;
    logic [TIME_W-1:0]      r_now;

    // Tracker state.
    logic [PHASE_W-1:0]     r_phase,   n_phase;
    logic [TIME_W-1:0]      r_phase_t, n_phase_t;
    t_fret_idx              r_cur,     n_cur;
    t_fret_idx              r_pend,    n_pend;
    logic [TIME_W-1:0]      r_jump_t,  n_jump_t;
    logic                   r_armed,   n_armed;
    logic                   r_snd_v,   n_snd_v;
    t_note                  r_snd_n,   n_snd_n;

    // Result register.
    logic                   r_out_valid;
    logic                   r_present;
    logic [FRET_NUM_W-1:0]  r_fret_num;
    logic                   r_on_v;
    t_note                  r_on_n;
    logic                   r_off_v;
    t_note                  r_off_n;

    logic                   accept;
    logic                   apply;
    logic                   mem_we;
    t_fret_idx              mem_raddr;
    t_sample                mem_rdata;
    t_scan_req              scan_req;
    t_scan_rsp              scan_rsp;

    logic                   do_change;
    t_note                  chg_note;
    logic                   do_silence;
    logic                   on_v;
    t_note                  on_n;
    logic                   off_v;
    t_note                  off_n;
    logic                   present_n;
    logic                   press_elapsed;
    logic                   release_elapsed;
    logic                   jump_elapsed;
    logic [TIME_W-1:0]      jump_base;
    logic                   adjacent;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    // A sample waits for the scan; everything else applies without waiting for it.
    // The result register must be free or being emptied.
    assign apply = (r_state == ST_RUN) && ((r_op != OP_SAMPLE) || scan_rsp.done) &&
                   (!r_out_valid || i_out_ready);

    // Loads write the memory on their input transfer; the scan only runs for
    // samples, one item at a time, so a read never meets a write in flight.
    assign mem_we = accept && (i_opcode == OP_LOAD) &&
                    ((CAL_IDX_W + 1)'(i_cal_index) < CAL_LIMIT);

    fpt_cal_mem u_cal_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (mem_we),
        .i_waddr (i_cal_index[FRET_IDX_W-1:0]),
        .i_wdata (i_cal_value),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign scan_req.start  = accept && (i_opcode == OP_SAMPLE);
    assign scan_req.value  = r_med;
    assign scan_req.cur    = r_cur;
    assign scan_req.margin = r_margin;

    fpt_fret_scan u_fret_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (scan_req),
        .o_rsp   (scan_rsp),
        .o_raddr (mem_raddr),
        .i_rdata (mem_rdata)
    );

    // Elapsed times are taken modulo 2^32, so a wrapping clock is harmless.
    assign press_elapsed   = (r_now - r_phase_t) >= TIME_W'(r_press_ms);
    assign release_elapsed = (r_now - r_phase_t) >= TIME_W'(r_release_ms);
    // The jump window opens with this very sample when no jump was pending.
    assign jump_base       = (r_pend == r_cur) ? r_now : r_jump_t;
    assign jump_elapsed    = (r_now - jump_base) >= TIME_W'(r_jump_ms);
    assign adjacent        = ((FRET_IDX_W + 1)'(scan_rsp.hyst) ==
                              (FRET_IDX_W + 1)'(r_cur) + (FRET_IDX_W + 1)'(1)) ||
                             ((FRET_IDX_W + 1)'(r_cur) ==
                              (FRET_IDX_W + 1)'(scan_rsp.hyst) + (FRET_IDX_W + 1)'(1));

    always_comb begin
        n_phase    = r_phase;
        n_phase_t  = r_phase_t;
        n_cur      = r_cur;
        n_pend     = r_pend;
        n_jump_t   = r_jump_t;
        n_armed    = r_armed;
        n_snd_v    = r_snd_v;
        n_snd_n    = r_snd_n;
        do_change  = 1'b0;
        chg_note   = '0;
        do_silence = 1'b0;
        on_v       = 1'b0;
        on_n       = '0;
        off_v      = 1'b0;
        off_n      = '0;

        case (r_op)
            OP_SAMPLE: begin
                case (r_phase)
                    PH_NONE: begin
                        if (r_med > r_press_th) begin
                            n_phase   = PH_PRESSING;
                            n_phase_t = r_now;
                        end
                    end
                    PH_PRESSING: begin
                        if (r_med <= r_press_th) begin
                            n_phase = PH_NONE;
                        end else if (press_elapsed) begin
                            n_phase   = PH_DOWN;
                            n_cur     = scan_rsp.raw;
                            n_pend    = scan_rsp.raw;
                            do_change = r_armed;
                            chg_note  = fretted_note(r_open_note, scan_rsp.raw);
                        end
                    end
                    PH_DOWN: begin
                        if (r_med < r_release_th) begin
                            n_phase   = PH_RELEASING;
                            n_phase_t = r_now;
                        end else if (scan_rsp.hyst == r_cur) begin
                            n_pend = r_cur;
                        end else begin
                            if (r_pend == r_cur) begin
                                n_jump_t = r_now;
                            end
                            n_pend = scan_rsp.hyst;
                            // Neighbor frets commit at once, jumps after the window.
                            if (adjacent || jump_elapsed) begin
                                n_cur     = scan_rsp.hyst;
                                do_change = r_armed;
                                chg_note  = fretted_note(r_open_note, scan_rsp.hyst);
                            end
                        end
                    end
                    default: begin
                        if (r_med >= r_release_th) begin
                            n_phase = PH_DOWN;
                        end else if (release_elapsed) begin
                            n_phase    = PH_NONE;
                            n_cur      = '0;
                            n_pend     = '0;
                            do_silence = r_armed;
                        end
                    end
                endcase
            end
            OP_STRUM: begin
                // A strum with no finger down is ignored.
                if (r_phase == PH_DOWN || r_phase == PH_RELEASING) begin
                    n_armed   = 1'b1;
                    do_change = 1'b1;
                    chg_note  = fretted_note(r_open_note, r_cur);
                end
            end
            default: begin
            end
        endcase

        // Legato change: the new note-on and the old note-off share one
        // result; re-sounding the same note sends no note-off.
        if (do_change) begin
            on_v = 1'b1;
            on_n = chg_note;
            if (r_snd_v && r_snd_n != chg_note) begin
                off_v = 1'b1;
                off_n = r_snd_n;
            end
            n_snd_v = 1'b1;
            n_snd_n = chg_note;
        end
        if (do_silence) begin
            if (r_snd_v) begin
                off_v = 1'b1;
                off_n = r_snd_n;
            end
            n_snd_v = 1'b0;
            n_snd_n = '0;
            n_armed = 1'b0;
        end
    end

    assign present_n = (n_phase == PH_DOWN) || (n_phase == PH_RELEASING);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_press_th   <= RST_PRESS_TH;
            r_release_th <= RST_RELEASE_TH;
            r_margin     <= RST_MARGIN;
            r_press_ms   <= RST_PRESS_MS;
            r_release_ms <= RST_RELEASE_MS;
            r_jump_ms    <= RST_JUMP_MS;
            r_open_note  <= RST_OPEN_NOTE;
            r_phase      <= PH_NONE;
            r_phase_t    <= '0;
            r_cur        <= '0;
            r_pend       <= '0;
            r_jump_t     <= '0;
            r_armed      <= 1'b0;
            r_snd_v      <= 1'b0;
            r_snd_n      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_PRESS_TH:   r_press_th   <= i_cfg_data[SAMPLE_W-1:0];
                    CFG_RELEASE_TH: r_release_th <= i_cfg_data[SAMPLE_W-1:0];
                    CFG_MARGIN:     r_margin     <= i_cfg_data[MARGIN_W-1:0];
                    CFG_PRESS_MS:   r_press_ms   <= i_cfg_data;
                    CFG_RELEASE_MS: r_release_ms <= i_cfg_data;
                    CFG_JUMP_MS:    r_jump_ms    <= i_cfg_data;
                    CFG_OPEN_NOTE:  r_open_note  <= i_cfg_data[NOTE_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (accept) begin
                r_state <= ST_RUN;
            end else if (apply) begin
                r_state <= ST_IDLE;
            end

            if (apply) begin
                r_phase     <= n_phase;
                r_phase_t   <= n_phase_t;
                r_cur       <= n_cur;
                r_pend      <= n_pend;
                r_jump_t    <= n_jump_t;
                r_armed     <= n_armed;
                r_snd_v     <= n_snd_v;
                r_snd_n     <= n_snd_n;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_opcode;
            r_med <= median3(i_sample_a, i_sample_b, i_sample_c);
            r_now <= i_now_ms;
        end
        if (apply) begin
            r_present  <= present_n;
            r_fret_num <= present_n ?
                          FRET_NUM_W'((FRET_IDX_W + 1)'(n_cur) + (FRET_IDX_W + 1)'(1)) : '0;
            r_on_v     <= on_v;
            r_on_n     <= on_n;
            r_off_v    <= off_v;
            r_off_n    <= off_n;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_finger_present  = r_present;
    assign o_fret_number     = r_fret_num;
    assign o_note_on_valid   = r_on_v;
    assign o_note_on_number  = r_on_n;
    assign o_note_off_valid  = r_off_v;
    assign o_note_off_number = r_off_n;

    // A sample must not be applied before the boundary scan has finished.
    a_sample_waits_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && r_op == OP_SAMPLE && !scan_rsp.done) |=> (r_state == ST_RUN))
        else $error("sample applied before scan finished");

    // A legato change never turns off the note it turns on.
    a_legato_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_note_on_valid && o_note_off_valid) |->
        (o_note_on_number != o_note_off_number))
        else $error("note-off matches note-on in one result");

    // A note only sounds on an armed string, and a silent string holds note zero.
    a_sounding_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_snd_v || r_armed) && (r_snd_v || (r_snd_n == '0)))
        else $error("sounding state inconsistent with arming");

    // Committed and pending frets stay inside the calibrated range.
    a_fret_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur <= LAST_FRET) && (r_pend <= LAST_FRET))
        else $error("fret index out of range");

endmodule

### hw/rtl/fpt_cal_mem.sv
// Calibration memory of the fret position tracker: one write port, one
// registered read port, per-entry written bits that fall back to the defaults.
// Depends on fpt_pkg.
module fpt_cal_mem (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_we,
    input  fpt_pkg::t_fret_idx i_waddr,
    input  fpt_pkg::t_sample   i_wdata,
    input  fpt_pkg::t_fret_idx i_raddr,
    output fpt_pkg::t_sample   o_rdata
);
    import fpt_pkg::*;

    t_sample                 mem [FRET_COUNT];
    logic [FRET_COUNT-1:0]   r_written;
    t_sample                 r_q;
    logic                    r_q_written;
    t_fret_idx               r_q_addr;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_q      <= mem[i_raddr];
        r_q_addr <= i_raddr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written   <= '0;
            r_q_written <= 1'b0;
        end else begin
            if (i_we) begin
                r_written[i_waddr] <= 1'b1;
            end
            r_q_written <= r_written[i_raddr];
        end
    end

    // An entry never loaded reads as its factory value.
    assign o_rdata = r_q_written ? r_q : default_center(CAL_IDX_W'(r_q_addr));

endmodule

### hw/rtl/fpt_fret_scan.sv
// Boundary scanner of the fret position tracker: walks the calibration memory
// one entry per cycle, finds the raw fret and applies the hysteresis window.
// Depends on fpt_pkg; drives the read port of fpt_cal_mem.
module fpt_fret_scan (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fpt_pkg::t_scan_req i_req,
    output fpt_pkg::t_scan_rsp o_rsp,
    output fpt_pkg::t_fret_idx o_raddr,
    input  fpt_pkg::t_sample   i_rdata
);
    import fpt_pkg::*;

    logic      r_issue;
    t_fret_idx r_addr;
    logic      r_dv;
    t_fret_idx r_didx;
    t_sample   r_prev;
    logic      r_found;
    t_fret_idx r_found_idx;
    t_sample   r_bhi;
    t_sample   r_blo;
    logic      r_fin;

    logic [SAMPLE_W:0] bnd_sum;
    t_sample           bnd;
    t_fret_idx         bi;
    logic              bnd_ok;
    logic              hit;
    logic              in_hi;
    logic              in_lo;
    t_fret_idx         raw;

    // Boundary between entry didx-1 and entry didx, once both have been read.
    assign bnd_sum = {1'b0, r_prev} + {1'b0, i_rdata};
    assign bnd     = bnd_sum[SAMPLE_W:1];
    assign bi      = r_didx - FRET_IDX_W'(1);
    assign bnd_ok  = r_dv && (r_didx != '0);
    assign hit     = i_req.value > bnd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue <= 1'b0;
            r_dv    <= 1'b0;
            r_found <= 1'b0;
            r_fin   <= 1'b0;
        end else begin
            r_dv <= r_issue;
            if (i_req.start) begin
                r_issue <= 1'b1;
                r_found <= 1'b0;
                r_fin   <= 1'b0;
            end else begin
                if (r_issue && r_addr == LAST_FRET) begin
                    r_issue <= 1'b0;
                end
                if (bnd_ok && !r_found && hit) begin
                    r_found <= 1'b1;
                end
                if (r_dv && r_didx == LAST_FRET) begin
                    r_fin <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_didx <= r_addr;
        if (i_req.start) begin
            r_addr <= '0;
        end else if (r_issue && r_addr != LAST_FRET) begin
            r_addr <= r_addr + FRET_IDX_W'(1);
        end
        if (r_dv) begin
            r_prev <= i_rdata;
        end
        if (bnd_ok && !r_found && hit) begin
            r_found_idx <= bi;
        end
        // Upper edge of the current fret is the boundary below its index.
        if (bnd_ok && r_didx == i_req.cur) begin
            r_bhi <= bnd;
        end
        if (bnd_ok && bi == i_req.cur) begin
            r_blo <= bnd;
        end
    end

    assign raw   = r_found ? r_found_idx : LAST_FRET;
    assign in_hi = (i_req.cur == '0) ||
                   ({1'b0, i_req.value} <= ({1'b0, r_bhi} + (SAMPLE_W + 1)'(i_req.margin)));
    assign in_lo = (i_req.cur == LAST_FRET) ||
                   (({1'b0, i_req.value} + (SAMPLE_W + 1)'(i_req.margin)) >= {1'b0, r_blo});

    assign o_rsp.done = r_fin;
    assign o_rsp.raw  = raw;
    assign o_rsp.hyst = (in_hi && in_lo) ? i_req.cur : raw;
    assign o_raddr    = r_addr;

endmodule

### tb/tb_fret_position_tracker.sv
// Self-checking testbench for the fret position tracker: random finger gestures,
// strums and calibration loads, checked against a cycle-free model of the tracker.
// Depends on fpt_pkg and fret_position_tracker.
module tb_fret_position_tracker;
    import fpt_pkg::*;

    // Cycles with no transfer on any channel before the run is declared hung.
    localparam int STALL_LIMIT = 1000;
    // Cycles allowed after the last result for stray output to show up.
    localparam int SETTLE_CYCLES = 40;
    // Upper bound of the hysteresis window when the finger sits on the first fret.
    localparam int READING_CEIL = 1024;
    localparam int READING_MAX = 1023;
    // Opcode value that the block does not define.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int FACTORY_CENTERS [FRET_COUNT] = '{
        998, 916, 828, 756, 681, 613, 551, 503, 438,
        391, 344, 291, 250, 208, 169, 133, 99
    };

    typedef struct {
        logic [OP_W-1:0]      op;
        t_sample              a;
        t_sample              b;
        t_sample              c;
        logic [TIME_W-1:0]    now;
        logic [CAL_IDX_W-1:0] idx;
        t_sample              val;
    } t_sensor_item;

    typedef struct {
        logic                  finger;
        logic [FRET_NUM_W-1:0] fret;
        logic                  on_v;
        t_note                 on_n;
        logic                  off_v;
        t_note                 off_n;
    } t_tracker_status;

    // The scoreboard carries its own copy of the tracker state and predicts the
    // status of every accepted item; results are matched in order against it.
    class fret_scoreboard;
        t_sample              press_th;
        t_sample              release_th;
        logic [MARGIN_W-1:0]  margin;
        logic [CONF_MS_W-1:0] press_ms;
        logic [CONF_MS_W-1:0] release_ms;
        logic [CONF_MS_W-1:0] jump_ms;
        t_note                open_note;

        logic [PHASE_W-1:0]   phase;
        logic [TIME_W-1:0]    phase_t0;
        logic [TIME_W-1:0]    jump_t0;
        t_fret_idx            cur_fret;
        t_fret_idx            pend_fret;
        bit                   armed;
        bit                   sounding;
        t_note                sound_note;
        t_sample              centers [FRET_COUNT];

        bit                   on_v;
        bit                   off_v;
        t_note                on_n;
        t_note                off_n;

        t_tracker_status      pending_status [$];
        int                   errors;

        function new();
            press_th   = RST_PRESS_TH;
            release_th = RST_RELEASE_TH;
            margin     = RST_MARGIN;
            press_ms   = RST_PRESS_MS;
            release_ms = RST_RELEASE_MS;
            jump_ms    = RST_JUMP_MS;
            open_note  = RST_OPEN_NOTE;
            phase      = PH_NONE;
            phase_t0   = '0;
            jump_t0    = '0;
            cur_fret   = '0;
            pend_fret  = '0;
            armed      = 0;
            sounding   = 0;
            sound_note = '0;
            errors     = 0;
            for (int i = 0; i < FRET_COUNT; i++) begin
                centers[i] = t_sample'(FACTORY_CENTERS[i]);
            end
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_PRESS_TH:   press_th   = data[SAMPLE_W-1:0];
                CFG_RELEASE_TH: release_th = data[SAMPLE_W-1:0];
                CFG_MARGIN:     margin     = data[MARGIN_W-1:0];
                CFG_PRESS_MS:   press_ms   = data;
                CFG_RELEASE_MS: release_ms = data;
                CFG_JUMP_MS:    jump_ms    = data;
                CFG_OPEN_NOTE:  open_note  = data[NOTE_W-1:0];
                default: ;
            endcase
        endfunction

        // Reading halfway between the centers of fret i and fret i+1.
        function int boundary(int i);
            return (int'(centers[i]) + int'(centers[i + 1])) / 2;
        endfunction

        function t_fret_idx raw_fret(int v);
            for (int i = 0; i < FRET_COUNT - 1; i++) begin
                if (v > boundary(i)) return t_fret_idx'(i);
            end
            return LAST_FRET;
        endfunction

        // The current fret is kept while the reading stays within its
        // boundaries widened by the margin.
        function t_fret_idx hyst_fret(int v);
            int hi;
            int lo;
            hi = (cur_fret == 0) ? READING_CEIL : boundary(int'(cur_fret) - 1) + int'(margin);
            lo = (cur_fret == LAST_FRET) ? 0 : boundary(int'(cur_fret)) - int'(margin);
            if (v <= hi && v >= lo) return cur_fret;
            return raw_fret(v);
        endfunction

        function bit finger_down();
            return phase == PH_DOWN || phase == PH_RELEASING;
        endfunction

        function t_note target_note();
            int n;
            n = finger_down() ? int'(open_note) + int'(cur_fret) + 1 : int'(open_note);
            return (n > int'(NOTE_MAX)) ? NOTE_MAX : t_note'(n);
        endfunction

        // Legato change: the old note is only released when it differs.
        function void commit_note();
            t_note n;
            n = target_note();
            on_v = 1;
            on_n = n;
            if (sounding && sound_note != n) begin
                off_v = 1;
                off_n = sound_note;
            end
            sounding   = 1;
            sound_note = n;
        endfunction

        function void mute_string();
            if (sounding) begin
                off_v = 1;
                off_n = sound_note;
            end
            sounding   = 0;
            sound_note = '0;
            armed      = 0;
        endfunction

        function t_sample mid_reading(t_sample a, t_sample b, t_sample c);
            t_sample lo;
            t_sample hi;
            t_sample m;
            lo = (a < b) ? a : b;
            hi = (a < b) ? b : a;
            m  = (hi < c) ? hi : c;
            return (lo > m) ? lo : m;
        endfunction

        function void qualify_sample(t_sample v, logic [TIME_W-1:0] now);
            t_fret_idx         t;
            int                span;
            logic [TIME_W-1:0] elapsed;
            case (phase)
                PH_NONE: begin
                    if (v > press_th) begin
                        phase    = PH_PRESSING;
                        phase_t0 = now;
                    end
                end
                PH_PRESSING: begin
                    elapsed = now - phase_t0;
                    if (v <= press_th) begin
                        phase = PH_NONE;
                    end else if (elapsed >= TIME_W'(press_ms)) begin
                        phase     = PH_DOWN;
                        cur_fret  = raw_fret(int'(v));
                        pend_fret = cur_fret;
                        if (armed) commit_note();
                    end
                end
                PH_DOWN: begin
                    if (v < release_th) begin
                        phase    = PH_RELEASING;
                        phase_t0 = now;
                    end else begin
                        t = hyst_fret(int'(v));
                        if (t == cur_fret) begin
                            pend_fret = t;
                        end else begin
                            // A fresh move away from the committed fret opens the window.
                            if (pend_fret == cur_fret) jump_t0 = now;
                            pend_fret = t;
                            span = (t > cur_fret) ? int'(t) - int'(cur_fret)
                                                  : int'(cur_fret) - int'(t);
                            elapsed = now - jump_t0;
                            if (span == 1 || elapsed >= TIME_W'(jump_ms)) begin
                                cur_fret  = t;
                                pend_fret = t;
                                if (armed) commit_note();
                            end
                        end
                    end
                end
                default: begin
                    elapsed = now - phase_t0;
                    if (v >= release_th) begin
                        phase = PH_DOWN;
                    end else if (elapsed >= TIME_W'(release_ms)) begin
                        phase     = PH_NONE;
                        cur_fret  = '0;
                        pend_fret = '0;
                        if (armed) mute_string();
                    end
                end
            endcase
        endfunction

        // Called for every accepted input transfer.
        function void take_item(t_sensor_item it);
            t_tracker_status st;
            on_v  = 0;
            off_v = 0;
            on_n  = '0;
            off_n = '0;
            case (it.op)
                OP_SAMPLE: qualify_sample(mid_reading(it.a, it.b, it.c), it.now);
                OP_STRUM: begin
                    if (finger_down()) begin
                        armed = 1;
                        commit_note();
                    end
                end
                OP_LOAD: begin
                    if (it.idx < FRET_COUNT) centers[it.idx] = it.val;
                end
                default: ;
            endcase
            st.finger = finger_down();
            st.fret   = finger_down() ? FRET_NUM_W'(int'(cur_fret) + 1) : '0;
            st.on_v   = on_v;
            st.on_n   = on_n;
            st.off_v  = off_v;
            st.off_n  = off_n;
            pending_status.push_back(st);
        endfunction

        function void compare(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        // Called for every accepted result transfer.
        function void check_status(t_tracker_status got);
            t_tracker_status want;
            if (pending_status.size() == 0) begin
                $display("%0t: result with no item outstanding, expected none actual fret %0d",
                         $time, got.fret);
                errors++;
                return;
            end
            want = pending_status.pop_front();
            compare("finger_present", want.finger, got.finger);
            compare("fret_number", want.fret, got.fret);
            compare("note_on_valid", want.on_v, got.on_v);
            compare("note_on_number", want.on_n, got.on_n);
            compare("note_off_valid", want.off_v, got.off_v);
            compare("note_off_number", want.off_n, got.off_n);
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_ready;
    logic [OP_W-1:0]        i_opcode = OP_SAMPLE;
    t_sample                i_sample_a = '0;
    t_sample                i_sample_b = '0;
    t_sample                i_sample_c = '0;
    logic [TIME_W-1:0]      i_now_ms = '0;
    logic [CAL_IDX_W-1:0]   i_cal_index = '0;
    t_sample                i_cal_value = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    logic                   o_finger_present;
    logic [FRET_NUM_W-1:0]  o_fret_number;
    logic                   o_note_on_valid;
    t_note                  o_note_on_number;
    logic                   o_note_off_valid;
    t_note                  o_note_off_number;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    fret_scoreboard         sb;
    // While set, neither side idles.
    bit                     steady = 0;
    // Time stamp of the most recent sample; advances by each sample's step and is at times set at random.
    logic [TIME_W-1:0]      clock_ms = '0;
    // Items that do real work; unused opcodes and out-of-range loads do not count.
    int                     items_sent = 0;
    int                     idle_cycles = 0;

    fret_position_tracker u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_opcode          (i_opcode),
        .i_sample_a        (i_sample_a),
        .i_sample_b        (i_sample_b),
        .i_sample_c        (i_sample_c),
        .i_now_ms          (i_now_ms),
        .i_cal_index       (i_cal_index),
        .i_cal_value       (i_cal_value),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_finger_present  (o_finger_present),
        .o_fret_number     (o_fret_number),
        .o_note_on_valid   (o_note_on_valid),
        .o_note_on_number  (o_note_on_number),
        .o_note_off_valid  (o_note_off_valid),
        .o_note_off_number (o_note_off_number),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // The result side stalls at random unless a steady stretch is running.
    always @(posedge i_clk) begin
        i_out_ready <= steady || ($urandom_range(99) >= 37);
    end

    // Every result transfer is checked against the oldest prediction. All
    // signals are read at the edge, before any of this edge's updates land.
    always @(posedge i_clk) begin
        t_tracker_status got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.finger = o_finger_present;
            got.fret   = o_fret_number;
            got.on_v   = o_note_on_valid;
            got.on_n   = o_note_on_number;
            got.off_v  = o_note_off_valid;
            got.off_n  = o_note_off_number;
            sb.check_status(got);
        end
    end

    // Watchdog: the run is hung if no channel has moved for a long time.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic int clip_reading(int v);
        if (v < 0) return 0;
        if (v > READING_MAX) return READING_MAX;
        return v;
    endfunction

    // Every field carries random content; the sender then overrides what the
    // item actually uses.
    function automatic t_sensor_item random_item();
        t_sensor_item it;
        it.op  = OP_SAMPLE;
        it.a   = t_sample'($urandom);
        it.b   = t_sample'($urandom);
        it.c   = t_sample'($urandom);
        it.now = $urandom;
        it.idx = CAL_IDX_W'($urandom);
        it.val = t_sample'($urandom);
        return it;
    endfunction

    // Presents one item and returns at the edge where its transfer happens.
    // The valid is left high so a following item can follow back to back.
    task automatic send_item(input t_sensor_item it);
        if (!steady) begin
            while ($urandom_range(99) < 37) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid  <= 1'b1;
        i_opcode    <= it.op;
        i_sample_a  <= it.a;
        i_sample_b  <= it.b;
        i_sample_c  <= it.c;
        i_now_ms    <= it.now;
        i_cal_index <= it.idx;
        i_cal_value <= it.val;
        do @(posedge i_clk); while (!o_in_ready);
        sb.take_item(it);
        if (it.op == OP_SAMPLE || it.op == OP_STRUM
                || (it.op == OP_LOAD && it.idx < FRET_COUNT)) begin
            items_sent++;
        end
    endtask

    task automatic send_raw(input int a, input int b, input int c, input int dt);
        t_sensor_item it;
        it = random_item();
        clock_ms = clock_ms + TIME_W'(dt);
        it.op  = OP_SAMPLE;
        it.a   = t_sample'(a);
        it.b   = t_sample'(b);
        it.c   = t_sample'(c);
        it.now = clock_ms;
        send_item(it);
    endtask

    // Three readings whose median is v, in random order.
    task automatic send_sample(input int v, input int dt);
        int lo;
        int hi;
        lo = int'($urandom_range(v, 0));
        hi = int'($urandom_range(READING_MAX, v));
        case ($urandom_range(5))
            0: send_raw(lo, v, hi, dt);
            1: send_raw(lo, hi, v, dt);
            2: send_raw(v, lo, hi, dt);
            3: send_raw(v, hi, lo, dt);
            4: send_raw(hi, lo, v, dt);
            default: send_raw(hi, v, lo, dt);
        endcase
    endtask

    task automatic send_strum();
        t_sensor_item it;
        it = random_item();
        it.op = OP_STRUM;
        send_item(it);
    endtask

    task automatic send_load(input int idx, input int val);
        t_sensor_item it;
        it = random_item();
        it.op  = OP_LOAD;
        it.idx = CAL_IDX_W'(idx);
        it.val = t_sample'(val);
        send_item(it);
    endtask

    task automatic send_unused_op();
        t_sensor_item it;
        it = random_item();
        it.op = OP_UNUSED;
        send_item(it);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DATA_W'(data);
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, CFG_DATA_W'(data));
    endtask

    // Only called with no item in flight.
    task automatic load_settings(input int press_th, input int release_th, input int margin,
                                 input int press_ms, input int release_ms, input int jump_ms,
                                 input int open_note);
        write_register(CFG_PRESS_TH, press_th);
        write_register(CFG_RELEASE_TH, release_th);
        write_register(CFG_MARGIN, margin);
        write_register(CFG_PRESS_MS, press_ms);
        write_register(CFG_RELEASE_MS, release_ms);
        write_register(CFG_JUMP_MS, jump_ms);
        write_register(CFG_OPEN_NOTE, open_note);
        i_cfg_valid <= 1'b0;
    endtask

    // The sender holds off until every predicted result has come back.
    task automatic quiet_and_drain();
        i_in_valid <= 1'b0;
        while (sb.pending_status.size() != 0) @(posedge i_clk);
    endtask

    // Time step between samples, scaled so that a confirmation window of
    // the given length is crossed within a few samples.
    function automatic int hold_step(input logic [CONF_MS_W-1:0] ms);
        return int'($urandom_range(int'(ms) / 2 + 3, 0));
    endfunction

    function automatic int fret_reading(input int f);
        return clip_reading(int'(sb.centers[f]) + int'($urandom_range(24)) - 12);
    endfunction

    // A reading right at the edge of the hysteresis window around a fret.
    function automatic int edge_reading(input int f);
        int b;
        b = (f < FRET_COUNT - 1) ? sb.boundary(f) - int'(sb.margin)
                                 : sb.boundary(f - 1) + int'(sb.margin);
        if ($urandom_range(1) == 1) b = sb.boundary((f > 0) ? f - 1 : 0) + int'(sb.margin);
        return clip_reading(b + int'($urandom_range(2)) - 1);
    endfunction

    // Mostly a lifted finger, now and then a bounce back onto the string.
    function automatic int lift_reading();
        if (sb.release_th == 0 || $urandom_range(99) < 15) begin
            return int'($urandom_range(READING_MAX, int'(sb.release_th)));
        end
        return int'($urandom_range(int'(sb.release_th) - 1, 0));
    endfunction

    // A whole note: press and confirm, maybe strum, slide and jump along the
    // neck, then lift and let the release confirm.
    task automatic play_gesture();
        int aim;
        int next;
        int steps;
        int k;
        int j;
        int r;
        aim = int'($urandom_range(FRET_COUNT - 1));
        steps = int'($urandom_range(4, 1));
        for (k = 0; k < steps; k++) send_sample(fret_reading(aim), hold_step(sb.press_ms));
        if ($urandom_range(99) < 75) send_strum();
        steps = int'($urandom_range(12, 2));
        for (k = 0; k < steps; k++) begin
            r = int'($urandom_range(99));
            if (r < 45) begin
                next = ($urandom_range(1) == 1) ? aim + 1 : aim - 1;
                if (next < 0) next = 1;
                if (next > FRET_COUNT - 1) next = FRET_COUNT - 2;
                send_sample(fret_reading(next), int'($urandom_range(6)));
                aim = next;
            end else if (r < 62) begin
                send_sample(fret_reading(aim), int'($urandom_range(6)));
            end else if (r < 82) begin
                // Jump: hold the far fret until the window has a chance to close.
                next = int'($urandom_range(FRET_COUNT - 1));
                for (j = int'($urandom_range(4, 1)); j > 0; j--) begin
                    send_sample(fret_reading(next), hold_step(sb.jump_ms));
                end
                aim = next;
            end else if (r < 90) begin
                send_strum();
            end else begin
                send_sample(edge_reading(aim), int'($urandom_range(6)));
            end
        end
        steps = int'($urandom_range(5, 1));
        for (k = 0; k < steps; k++) send_sample(lift_reading(), hold_step(sb.release_ms));
    endtask

    // Items outside any gesture: junk readings, stray strums, loads, time jumps.
    task automatic noise_burst();
        int k;
        int r;
        int idx;
        for (k = int'($urandom_range(5, 1)); k > 0; k--) begin
            r = int'($urandom_range(99));
            if (r < 35) begin
                send_raw(int'($urandom_range(READING_MAX)), int'($urandom_range(READING_MAX)),
                         int'($urandom_range(READING_MAX)), int'($urandom_range(40)));
            end else if (r < 55) begin
                send_strum();
            end else if (r < 75) begin
                idx = int'($urandom_range(FRET_COUNT - 1));
                send_load(idx, clip_reading(FACTORY_CENTERS[idx] + int'($urandom_range(30)) - 15));
            end else if (r < 85) begin
                send_load(int'($urandom_range(31)), int'($urandom_range(READING_MAX)));
            end else if (r < 93) begin
                send_unused_op();
            end else begin
                clock_ms = $urandom;
                send_sample(int'($urandom_range(READING_MAX)), 0);
            end
        end
    endtask

    task automatic run_phase(input int count);
        int target;
        target = items_sent + count;
        while (items_sent < target) begin
            if ($urandom_range(99) < 70) play_gesture();
            else noise_burst();
        end
        quiet_and_drain();
    endtask

    // Short hand-picked sequence at reset settings: strum with no finger,
    // the undefined opcode, ignored and extreme loads, a press confirmed
    // across the wrap of the time counter, an adjacent move, a delayed jump,
    // a repeated strum on the same note and a confirmed release.
    task automatic run_directed();
        clock_ms = 32'hFFFF_FFF0;
        send_strum();
        send_unused_op();
        send_load(31, READING_MAX);
        send_load(FRET_COUNT, 0);
        send_load(0, READING_MAX);
        send_load(FRET_COUNT - 1, 0);
        send_raw(READING_MAX, READING_MAX, READING_MAX, 0);
        send_raw(0, READING_MAX, 700, 3);
        send_raw(READING_MAX, READING_MAX, READING_MAX, 14);
        send_strum();
        send_sample(916, 1);
        send_sample(613, 1);
        send_sample(613, 10);
        send_strum();
        send_raw(0, 0, 0, 1);
        send_raw(0, 0, 0, 200);
        send_load(0, FACTORY_CENTERS[0]);
        send_load(FRET_COUNT - 1, FACTORY_CENTERS[FRET_COUNT - 1]);
    endtask

    initial begin
        int pt;
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        quiet_and_drain();

        clock_ms = $urandom;
        load_settings(55, 35, 6, 4, 120, 8, 64);
        steady = 1;
        run_phase(150);
        steady = 0;
        run_phase(150);

        // Lowest values: any touch presses, nothing ever releases.
        load_settings(0, 0, 0, 0, 0, 0, 0);
        run_phase(150);

        // Highest values: pressing is impossible, windows are as long as they get.
        load_settings(1023, 1023, 255, 65535, 65535, 65535, 110);
        run_phase(60);

        load_settings(200, 150, 255, 65535, 65535, 65535, 110);
        run_phase(200);

        repeat (2) begin
            pt = int'($urandom_range(400, 40));
            load_settings(pt, int'($urandom_range(pt, 0)), int'($urandom_range(255)),
                          int'($urandom_range(200)), int'($urandom_range(300)),
                          int'($urandom_range(100)), int'($urandom_range(110)));
            run_phase(250);
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_status.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### filelist.f
hw/rtl/fpt_pkg.sv
hw/rtl/fpt_cal_mem.sv
hw/rtl/fpt_fret_scan.sv
hw/rtl/fret_position_tracker.sv
tb/tb_fret_position_tracker.sv
